@@ hw/rtl/vpz_pkg.sv @@
// Shared types and constants for the pan/zoom view transform.
// Used by the top level and its serial multiplier and divider.
// No dependencies.
package vpz_pkg;

  localparam int SCALE_W = 32;
  localparam int VP_W    = 16;
  localparam int CMD_W   = 3;
  localparam int REG_W   = 3;

  localparam logic [CMD_W-1:0] CMD_SET      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PAN      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ZOOM     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLAMP    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TO_WORLD = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CIRCLE   = 3'd5;

  localparam logic [REG_W-1:0] REG_MIN_SCALE = 3'd0;
  localparam logic [REG_W-1:0] REG_MAX_SCALE = 3'd1;
  localparam logic [REG_W-1:0] REG_VP_W      = 3'd2;
  localparam logic [REG_W-1:0] REG_VP_H      = 3'd3;
  localparam logic [REG_W-1:0] REG_WORLD_W   = 3'd4;
  localparam logic [REG_W-1:0] REG_WORLD_H   = 3'd5;

  // Which operand the sequencer works on.
  localparam logic [1:0] PH_X = 2'd0;
  localparam logic [1:0] PH_Y = 2'd1;
  localparam logic [1:0] PH_R = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_MSTART,
    S_MUL,
    S_MRND,
    S_MADD,
    S_CLAMP,
    S_DSTART,
    S_DIV,
    S_ZOOM,
    S_DPOST,
    S_OUT
  } st_t;

endpackage

@@ hw/rtl/vpz_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on vpz_pkg for the multiplier width.
module vpz_mul import vpz_pkg::*; #(
  parameter int MW = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [MW-1:0]         mcand,
  input  logic [SCALE_W-1:0]    mplier,
  output logic                  done,
  output logic [MW+SCALE_W-1:0] prod
);

  localparam int PW  = MW + SCALE_W;
  localparam int CNW = $clog2(SCALE_W + 1);

  logic [PW-1:0]  prod_r, prod_nxt;
  logic [MW-1:0]  mcand_r;
  logic [CNW-1:0] cnt_r;
  logic           busy_r, done_r;
  logic [MW:0]    sum;

  // The low half of the product register holds the multiplier, shifted out as
  // the partial sums shift in from the top.
  always_comb begin
    sum      = {1'b0, prod_r[PW-1:SCALE_W]} + (prod_r[0] ? {1'b0, mcand_r} : '0);
    prod_nxt = {sum, prod_r[SCALE_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNW'(1);
        if (cnt_r == CNW'(SCALE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r  <= {{MW{1'b0}}, mplier};
      mcand_r <= mcand;
    end else if (busy_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

@@ hw/rtl/vpz_div.sv @@
// Restoring divider, one quotient bit per cycle, 32-bit divisor.
// Depends on vpz_pkg for the divisor width.
module vpz_div import vpz_pkg::*; #(
  parameter int NW = 66
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [NW-1:0]      dividend,
  input  logic [SCALE_W-1:0] divisor,
  output logic               done,
  output logic [NW-1:0]      quo
);

  localparam int CNW = $clog2(NW + 1);

  logic [NW-1:0]      quo_r, quo_nxt;
  logic [SCALE_W-1:0] rem_r, rem_nxt, dvs_r;
  logic [CNW-1:0]     cnt_r;
  logic               busy_r, done_r;
  logic [SCALE_W:0]   trial, diff;
  logic               ge;

  always_comb begin
    trial   = {rem_r, quo_r[NW-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[SCALE_W-1:0] : trial[SCALE_W-1:0];
    quo_nxt = {quo_r[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNW'(1);
        if (cnt_r == CNW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

@@ hw/rtl/view_pan_zoom_transform.sv @@
// Pan/zoom camera: keeps origin and scale, runs one command per item.
// Set view, skipped zoom and unused codes go straight to the output; clamp, pan and
// screen to world use the multiplier, zoom the divider then the multiplier, and circle
// the divider alone. One item at a time: the next item is taken the cycle after the
// result loads, unless a waiting result stalls it.
// Synchronous active-low reset: origin 0, scale 1.0, registers to defaults.
module view_pan_zoom_transform import vpz_pkg::*; #(
  parameter int COORD_WIDTH = 48,
  parameter int FRAC_BITS   = 16
) (
  input  logic clk,
  input  logic rst_n,
  // in_tdata: arg_x, arg_y, arg_z (lowest first), zero padded
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  input  logic [((2*COORD_WIDTH+SCALE_W+7)/8)*8-1:0]    in_tdata,
  // in_tuser: command
  input  logic [CMD_W-1:0]                              in_tuser,
  // out_tdata: out_x, out_y, out_radius, view_x, view_y, view_scale, zero padded
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  output logic [((5*COORD_WIDTH-1+SCALE_W+7)/8)*8-1:0]  out_tdata,
  // out_tuser: ignored, overflow
  output logic [1:0]                                    out_tuser,
  input  logic                                          cfg_we,
  input  logic [REG_W-1:0]                              cfg_index,
  input  logic [((COORD_WIDTH-1 > SCALE_W) ? COORD_WIDTH-1 : SCALE_W)-1:0] cfg_wdata
);

  localparam int W      = COORD_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int MW     = (W > SCALE_W) ? W : SCALE_W;
  localparam int PW     = MW + SCALE_W;
  localparam int SW     = PW + 2;
  localparam int DVW    = MW + F + 2;
  localparam int OUT_DW = ((5*W - 1 + SCALE_W + 7) / 8) * 8;

  localparam logic [SCALE_W-1:0] ONE_SCALE = SCALE_W'(64'd1 << F);
  localparam logic [SCALE_W-1:0] MIN_RST   = SCALE_W'(((64'd1 << F) + 64'd5) / 64'd10);
  localparam logic [SCALE_W-1:0] MAX_RST   = SCALE_W'(64'd10 << F);
  localparam logic [VP_W-1:0]    VPW_RST   = VP_W'(800);
  localparam logic [VP_W-1:0]    VPH_RST   = VP_W'(600);
  localparam logic [W-2:0]       WW_RST    = (W-1)'(64'd2000 << F);
  localparam logic [W-2:0]       WH_RST    = (W-1)'(64'd1200 << F);

  localparam logic signed [SW-1:0] SMAX_SW = (SW'(1) << (W-1)) - SW'(1);
  localparam logic signed [SW-1:0] SMIN_SW = SW'(0) - (SW'(1) << (W-1));
  localparam logic [DVW-1:0]       HALF_DV = DVW'(1) << (W-1);
  localparam logic [PW:0]          RND_PW  = (PW+1)'(1) << (F-1);

  st_t state_r, state_nxt;

  logic [SCALE_W-1:0] min_r, max_r;
  logic [VP_W-1:0]    vpw_r, vph_r;
  logic [W-2:0]       ww_r, wh_r;

  logic signed [W-1:0] org_x_r, org_y_r;
  logic [SCALE_W-1:0]  scale_r;

  logic [CMD_W-1:0]    cmd_r;
  logic signed [W-1:0] ax_r, ay_r;
  logic [SCALE_W-1:0]  az_r;
  logic [1:0]          phase_r;
  logic                neg_r, kneg_r;
  logic [SCALE_W-1:0]  k_r;
  logic signed [SW-1:0] trm_r;
  logic [W-1:0]        rx_r, ry_r;
  logic [W-2:0]        rad_r;
  logic                ign_r, ovf_r;

  logic                out_valid_r;
  logic [OUT_DW-1:0]   out_data_r;
  logic [1:0]          out_user_r;

  logic                mul_start, mul_done, div_start, div_done;
  logic [MW-1:0]       mul_mcand;
  logic [SCALE_W-1:0]  mul_mplier, div_dvs;
  logic [PW-1:0]       prod;
  logic [DVW-1:0]      div_dvd, quo;
  logic                out_load;

  // Operand of the current axis.
  logic signed [W-1:0] a_sel, o_sel;
  logic [W-1:0]        cmag;
  logic                csign;
  logic signed [W:0]   dd;
  logic [W:0]          dmag;

  // Rounding and accumulation.
  logic [PW:0]          rnd;
  logic [SW-1:0]        tsw;
  logic signed [SW-1:0] trm_nxt, base_sw, sum_sw;
  logic [W:0]           sum_sat;

  // Clamp.
  logic signed [SW-1:0] ext_sw, wd_sw, diff_sw, r_lo, r_pos, r_cl;
  logic [W:0]           cl_sat;

  // Divider results.
  logic [W:0]           dq_sat;
  logic [W-1:0]         rad_sat;
  logic [DVW-1:0]       q_lo, q_hi;
  logic [SCALE_W-1:0]   ns;

  function automatic logic [W:0] sat_w(input logic signed [SW-1:0] v);
    logic [W:0] r;
    if (v > SMAX_SW) begin
      r = {1'b1, SMAX_SW[W-1:0]};
    end else if (v < SMIN_SW) begin
      r = {1'b1, SMIN_SW[W-1:0]};
    end else begin
      r = {1'b0, v[W-1:0]};
    end
    return r;
  endfunction

  vpz_mul #(.MW(MW)) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .done   (mul_done),
    .prod   (prod)
  );

  vpz_div #(.NW(DVW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quo      (quo)
  );

  always_comb begin
    a_sel = phase_r[0] ? ay_r : ax_r;
    o_sel = phase_r[0] ? org_y_r : org_x_r;
    csign = a_sel[W-1];
    cmag  = csign ? W'(-a_sel) : W'(a_sel);
    dd    = {a_sel[W-1], a_sel} - {o_sel[W-1], o_sel};
    dmag  = dd[W] ? (W+1)'(-dd) : (W+1)'(dd);

    if (cmd_r == CMD_CLAMP) begin
      mul_mcand  = MW'(scale_r);
      mul_mplier = SCALE_W'(phase_r[0] ? vph_r : vpw_r);
    end else begin
      mul_mcand  = MW'(cmag);
      mul_mplier = k_r;
    end

    if (cmd_r == CMD_ZOOM) begin
      div_dvd = (DVW'(scale_r) << F) + DVW'(az_r >> 1);
      div_dvs = az_r;
    end else if (phase_r == PH_R) begin
      div_dvd = (DVW'(az_r) << F) + DVW'(scale_r >> 1);
      div_dvs = scale_r;
    end else begin
      div_dvd = (DVW'(dmag) << F) + DVW'(scale_r >> 1);
      div_dvs = scale_r;
    end

    // Round half up on the magnitude, then apply the sign: half away from zero.
    rnd     = {1'b0, prod} + RND_PW;
    tsw     = SW'(rnd[PW:F]);
    trm_nxt = neg_r ? $signed(SW'(0) - tsw) : $signed(tsw);
    base_sw = {{(SW-W){o_sel[W-1]}}, o_sel};
    sum_sw  = base_sw + trm_r;
    sum_sat = sat_w(sum_sw);

    ext_sw  = SW'(prod[SCALE_W+VP_W-1:0]);
    wd_sw   = SW'(phase_r[0] ? wh_r : ww_r);
    diff_sw = ext_sw - wd_sw;
    r_lo    = SW'(0) - ((diff_sw + SW'(1)) >>> 1);
    r_pos   = o_sel[W-1] ? SW'(0) : base_sw;
    if (!diff_sw[SW-1]) begin
      // View wider than the world: center it.
      r_cl = r_lo;
    end else if (r_pos > (SW'(0) - diff_sw)) begin
      r_cl = SW'(0) - diff_sw;
    end else begin
      r_cl = r_pos;
    end
    cl_sat = sat_w(r_cl);

    if (neg_r) begin
      dq_sat = (quo > HALF_DV) ? {1'b1, SMIN_SW[W-1:0]} : {1'b0, W'(DVW'(0) - quo)};
    end else begin
      dq_sat = (quo > HALF_DV - DVW'(1)) ? {1'b1, SMAX_SW[W-1:0]} : {1'b0, quo[W-1:0]};
    end
    rad_sat = (quo > HALF_DV - DVW'(1)) ? {1'b1, {(W-1){1'b1}}} : {1'b0, quo[W-2:0]};

    q_lo = (quo < DVW'(min_r)) ? DVW'(min_r) : quo;
    q_hi = (q_lo > DVW'(max_r)) ? DVW'(max_r) : q_lo;
    ns   = (q_hi == '0) ? SCALE_W'(1) : q_hi[SCALE_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DISP;
      end
      S_DISP: begin
        case (cmd_r)
          CMD_PAN, CMD_TO_WORLD, CMD_CLAMP: state_nxt = S_MSTART;
          CMD_ZOOM:   state_nxt = (az_r == '0) ? S_OUT : S_DSTART;
          CMD_CIRCLE: state_nxt = S_DSTART;
          default:    state_nxt = S_OUT;
        endcase
      end
      S_MSTART: begin
        mul_start = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (mul_done) state_nxt = (cmd_r == CMD_CLAMP) ? S_CLAMP : S_MRND;
      end
      S_MRND: state_nxt = S_MADD;
      S_MADD, S_CLAMP: begin
        state_nxt = (phase_r == PH_X) ? S_MSTART : S_OUT;
      end
      S_DSTART: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_nxt = (cmd_r == CMD_ZOOM) ? S_ZOOM : S_DPOST;
      end
      S_ZOOM: state_nxt = S_MSTART;
      S_DPOST: begin
        state_nxt = (phase_r == PH_R) ? S_OUT : S_DSTART;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state, configuration and camera state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      min_r       <= MIN_RST;
      max_r       <= MAX_RST;
      vpw_r       <= VPW_RST;
      vph_r       <= VPH_RST;
      ww_r        <= WW_RST;
      wh_r        <= WH_RST;
      org_x_r     <= '0;
      org_y_r     <= '0;
      scale_r     <= ONE_SCALE;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (out_load) out_valid_r <= 1'b1;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_MIN_SCALE: min_r <= cfg_wdata[SCALE_W-1:0];
          REG_MAX_SCALE: max_r <= cfg_wdata[SCALE_W-1:0];
          REG_VP_W:      vpw_r <= cfg_wdata[VP_W-1:0];
          REG_VP_H:      vph_r <= cfg_wdata[VP_W-1:0];
          REG_WORLD_W:   ww_r  <= cfg_wdata[W-2:0];
          REG_WORLD_H:   wh_r  <= cfg_wdata[W-2:0];
          default: ;
        endcase
      end

      case (state_r)
        S_DISP: begin
          if (cmd_r == CMD_SET) begin
            org_x_r <= ax_r;
            org_y_r <= ay_r;
            scale_r <= (az_r != '0) ? az_r : ONE_SCALE;
          end
        end
        S_MADD: begin
          if (cmd_r != CMD_TO_WORLD) begin
            if (phase_r[0]) org_y_r <= sum_sat[W-1:0];
            else            org_x_r <= sum_sat[W-1:0];
          end
        end
        S_CLAMP: begin
          if (phase_r[0]) org_y_r <= cl_sat[W-1:0];
          else            org_x_r <= cl_sat[W-1:0];
        end
        S_ZOOM: scale_r <= ns;
        default: ;
      endcase
    end
  end

  // Item operands and working values.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_r <= in_tuser;
          ax_r  <= in_tdata[W-1:0];
          ay_r  <= in_tdata[2*W-1:W];
          az_r  <= in_tdata[2*W+SCALE_W-1:2*W];
        end
      end
      S_DISP: begin
        phase_r <= PH_X;
        rx_r    <= '0;
        ry_r    <= '0;
        rad_r   <= '0;
        ign_r   <= (cmd_r == CMD_ZOOM) && (az_r == '0);
        ovf_r   <= 1'b0;
        k_r     <= scale_r;
        kneg_r  <= 1'b0;
      end
      S_MSTART: neg_r <= csign ^ kneg_r;
      S_MRND:   trm_r <= trm_nxt;
      S_MADD: begin
        if (cmd_r == CMD_TO_WORLD) begin
          if (phase_r[0]) ry_r <= sum_sat[W-1:0];
          else            rx_r <= sum_sat[W-1:0];
        end
        ovf_r   <= ovf_r | sum_sat[W];
        phase_r <= PH_Y;
      end
      S_CLAMP: begin
        ovf_r   <= ovf_r | cl_sat[W];
        phase_r <= PH_Y;
      end
      S_DSTART: neg_r <= dd[W];
      S_ZOOM: begin
        kneg_r <= (ns > scale_r);
        k_r    <= (ns > scale_r) ? (ns - scale_r) : (scale_r - ns);
      end
      S_DPOST: begin
        if (phase_r == PH_R) begin
          rad_r <= rad_sat[W-2:0];
          ovf_r <= ovf_r | rad_sat[W-1];
        end else begin
          if (phase_r[0]) ry_r <= dq_sat[W-1:0];
          else            rx_r <= dq_sat[W-1:0];
          ovf_r <= ovf_r | dq_sat[W];
        end
        phase_r <= 2'(phase_r + 2'd1);
      end
      S_OUT: begin
        if (out_load) begin
          out_data_r <= OUT_DW'({scale_r, org_y_r, org_x_r, rad_r, ry_r, rx_r});
          out_user_r <= {ovf_r, ign_r};
        end
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ hw/rtl/vpz_chk.sv @@
// Port-level checks for the pan/zoom view transform, bound to its top level.
// Depends on view_pan_zoom_transform for the port names and field layout.
module vpz_chk #(
  parameter int COORD_WIDTH = 48
) (
  input logic                                       clk,
  input logic                                       rst_n,
  input logic                                       in_tvalid,
  input logic                                       in_tready,
  input logic                                       out_tvalid,
  input logic                                       out_tready,
  input logic [((5*COORD_WIDTH+31+7)/8)*8-1:0]      out_tdata,
  input logic [1:0]                                 out_tuser
);

  localparam int SC_LO = 5*COORD_WIDTH - 1;

  // A result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

  // The scale never reaches zero.
  a_scale_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[SC_LO+31:SC_LO] != 32'd0)
    else $error("zero scale reported");

  // A skipped zoom cannot saturate anything.
  a_ign_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tuser[1])
    else $error("ignored item reports overflow");

  // Reset empties the output register.
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind view_pan_zoom_transform vpz_chk #(.COORD_WIDTH(COORD_WIDTH)) u_vpz_chk (.*);
